FILE: hw/rtl/assert_macros.svh
// Assertion macros for the top-level RTL of the key/value table.
// Expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define KVCT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that an implication holds at every rising clock edge outside reset.
`define KVCT_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/kvct_pkg.sv
// Package for the key/value table: sizes, command and status codes,
// controller states and the search transaction carried along the cell chain.
`default_nettype none

package kvct_pkg;

	localparam int JAR_SLOTS   = 32;
	localparam int TABLE_DEPTH = JAR_SLOTS - 1;
	localparam int FILL_W      = $clog2(JAR_SLOTS);
	localparam int CNT_W       = 5;
	localparam int LIMIT_W     = 5;
	localparam int KEY_W       = 32;
	localparam int VAL_W       = 32;

	typedef enum logic {
		CMD_SET = 1'b0,
		CMD_GET = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_ZERO_KEY  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_DONE
	} state_t;

	// One search transaction as it moves from cell to cell.
	typedef struct packed {
		logic              valid;
		cmd_t              cmd;
		logic [KEY_W-1:0]  key;
		logic [VAL_W-1:0]  value;
		logic [FILL_W-1:0] rem;    // filled entries still ahead of this transaction
		logic              found;
		logic [VAL_W-1:0]  rd;
	} tok_t;

	// Append write broadcast to the cells.
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} app_t;

endpackage

`default_nettype wire

FILE: hw/rtl/kvct_cell.sv
// One table entry of the key/value table with its stage of the search chain.
// Depends on kvct_pkg for the transaction and append types.
`default_nettype none

module kvct_cell (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire kvct_pkg::tok_t tok_i,
	output kvct_pkg::tok_t     tok_o,
	input  wire logic          app_en,
	input  wire kvct_pkg::app_t app
);

	logic [kvct_pkg::KEY_W-1:0] key_q;
	logic [kvct_pkg::VAL_W-1:0] val_q;
	logic                       vld_q;
	kvct_pkg::tok_t             tok_q;
	kvct_pkg::tok_t             tok_d;
	logic                       filled;
	logic                       hit;

	always_comb begin
		filled = (tok_i.rem != '0);
		hit    = tok_i.valid && filled && !tok_i.found && (key_q == tok_i.key);
		tok_d  = tok_i;
		tok_d.found = tok_i.found || hit;
		tok_d.rem   = filled ? (tok_i.rem - kvct_pkg::FILL_W'(1)) : '0;
		if (hit && (tok_i.cmd == kvct_pkg::CMD_GET)) begin
			tok_d.rd = val_q;
		end
	end

	// Entry storage: append fills the slot, a matching set overwrites the value
	always_ff @(posedge clk) begin
		if (app_en) begin
			key_q <= app.key;
			val_q <= app.value;
		end else if (hit && (tok_i.cmd == kvct_pkg::CMD_SET)) begin
			val_q <= tok_i.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= tok_i.valid;
		end
	end

	always_ff @(posedge clk) begin
		tok_q <= tok_d;
	end

	always_comb begin
		tok_o       = tok_q;
		tok_o.valid = vld_q;
	end

endmodule

`default_nettype wire

FILE: hw/rtl/key_value_cookie_table_top.sv
// Key/value table: a search chain of one cell per entry and its controller.
// Depends on kvct_pkg, kvct_cell and assert_macros.svh.
//
// Usage:
//   Input channel (in_valid/in_ready, cmd, key, value) takes one command at a
//   time: a set (store or update a pair) or a get (look up a key).
//   Output channel (out_valid/out_ready, status, read_value, entry_count)
//   returns one result per command, in order.
//   Configuration channel (cfg_valid/cfg_ready, cfg_data) writes slot_limit;
//   it is always ready and must only be used while no command is in flight.
//   A command walks the 31-entry cell chain at one cell per cycle; the
//   controller then registers the transaction leaving the chain and, in its
//   done state, settles the outcome and any append. The next command is
//   accepted in the cycle after that, so commands never overlap in the chain.
//   If the receiver stalls, the result holds in the output register; the
//   next command may be accepted and searched, and its result waits until
//   the held one is taken.
//   Reset empties the table and sets slot_limit to 31; no clearing pass.
`default_nettype none

module key_value_cookie_table_top (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic                         cmd,
	input  wire logic [kvct_pkg::KEY_W-1:0]   key,
	input  wire logic [kvct_pkg::VAL_W-1:0]   value,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [1:0]                        status,
	output logic [kvct_pkg::VAL_W-1:0]        read_value,
	output logic [kvct_pkg::CNT_W-1:0]        entry_count,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [kvct_pkg::LIMIT_W-1:0] cfg_data
);

	`include "assert_macros.svh"

	kvct_pkg::state_t               state_q;
	kvct_pkg::state_t               state_d;
	logic [kvct_pkg::FILL_W-1:0]    fill_q;
	logic [kvct_pkg::FILL_W-1:0]    fill_d;
	logic [kvct_pkg::LIMIT_W-1:0]   slot_limit_q;
	logic [kvct_pkg::FILL_W-1:0]    limit_eff;
	kvct_pkg::tok_t                 chain [0:kvct_pkg::TABLE_DEPTH];
	logic [kvct_pkg::TABLE_DEPTH-1:0] tok_vld;
	logic [kvct_pkg::TABLE_DEPTH-1:0] app_sel;
	kvct_pkg::tok_t                 res_q;
	kvct_pkg::app_t                 app;
	logic                           finish;
	logic                           append_en;
	kvct_pkg::status_t              status_d;
	logic [kvct_pkg::VAL_W-1:0]     rd_d;
	logic                           out_valid_q;
	kvct_pkg::status_t              status_q;
	logic [kvct_pkg::VAL_W-1:0]     rd_q;
	logic [kvct_pkg::CNT_W-1:0]     cnt_q;

	assign cfg_ready = 1'b1;

	// Launch a search transaction into the first cell
	always_comb begin
		chain[0].valid = in_valid && in_ready;
		chain[0].cmd   = kvct_pkg::cmd_t'(cmd);
		chain[0].key   = key;
		chain[0].value = value;
		chain[0].rem   = fill_q;
		chain[0].found = 1'b0;
		chain[0].rd    = '0;
	end

	assign app.key   = res_q.key;
	assign app.value = res_q.value;

	for (genvar i = 0; i < kvct_pkg::TABLE_DEPTH; i++) begin : g_cell
		assign app_sel[i] = append_en && (fill_q == kvct_pkg::FILL_W'(i));
		assign tok_vld[i] = chain[i+1].valid;

		kvct_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.tok_i  (chain[i]),
			.tok_o  (chain[i+1]),
			.app_en (app_sel[i]),
			.app    (app)
		);
	end

	// Controller: next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			kvct_pkg::S_IDLE: begin
				if (in_valid) state_d = kvct_pkg::S_SEARCH;
			end
			kvct_pkg::S_SEARCH: begin
				if (chain[kvct_pkg::TABLE_DEPTH].valid) state_d = kvct_pkg::S_DONE;
			end
			kvct_pkg::S_DONE: begin
				if (!out_valid_q || out_ready) state_d = kvct_pkg::S_IDLE;
			end
			default: state_d = kvct_pkg::S_IDLE;
		endcase
	end

	// Controller: outputs
	always_comb begin
		in_ready = 1'b0;
		finish   = 1'b0;
		unique case (state_q)
			kvct_pkg::S_IDLE:   in_ready = 1'b1;
			kvct_pkg::S_SEARCH: ;
			kvct_pkg::S_DONE:   finish = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	// Clamp the limit to the table depth
	assign limit_eff = (32'(slot_limit_q) > 32'(kvct_pkg::TABLE_DEPTH))
		? kvct_pkg::FILL_W'(kvct_pkg::TABLE_DEPTH) : kvct_pkg::FILL_W'(slot_limit_q);

	// Settle the outcome of the finished search
	always_comb begin
		append_en = 1'b0;
		status_d  = kvct_pkg::ST_OK;
		rd_d      = '0;
		priority if (res_q.key == '0) begin
			status_d = kvct_pkg::ST_ZERO_KEY;
		end else if (res_q.cmd == kvct_pkg::CMD_GET) begin
			if (res_q.found) rd_d = res_q.rd;
			else status_d = kvct_pkg::ST_NOT_FOUND;
		end else if (res_q.found) begin
			status_d = kvct_pkg::ST_OK;
		end else if (fill_q < limit_eff) begin
			append_en = finish;
		end else begin
			status_d = kvct_pkg::ST_FULL;
		end
	end

	assign fill_d = append_en ? (fill_q + kvct_pkg::FILL_W'(1)) : fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= kvct_pkg::S_IDLE;
			fill_q       <= '0;
			slot_limit_q <= kvct_pkg::LIMIT_W'(31);
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
			if (cfg_valid && cfg_ready) slot_limit_q <= cfg_data;
			if (finish) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// Hold the search transaction as it leaves the chain, and the result
	always_ff @(posedge clk) begin
		if (state_q == kvct_pkg::S_SEARCH && chain[kvct_pkg::TABLE_DEPTH].valid) begin
			res_q <= chain[kvct_pkg::TABLE_DEPTH];
		end
		if (finish) begin
			status_q <= status_d;
			rd_q     <= rd_d;
			cnt_q    <= kvct_pkg::CNT_W'(fill_d);
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign read_value  = rd_q;
	assign entry_count = cnt_q;

	`KVCT_ASSERT(a_one_search, $onehot0(tok_vld), "more than one search in the chain")
	`KVCT_ASSERT_IMPL(a_fill_step, fill_q != $past(fill_q),
		fill_q == $past(fill_q) + kvct_pkg::FILL_W'(1), "fill count moved by other than one")
	`KVCT_ASSERT_IMPL(a_fill_max, 1'b1,
		32'(fill_q) <= 32'(kvct_pkg::TABLE_DEPTH), "fill count beyond table depth")
	`KVCT_ASSERT_IMPL(a_out_from_done, $rose(out_valid_q),
		$past(state_q) == kvct_pkg::S_DONE, "result raised outside completion")

endmodule

`default_nettype wire

FILE: tb/key_value_cookie_table_top_tb.sv
// Self-checking testbench for key_value_cookie_table_top: directed and random set/get
// commands, an in-line table predictor and result checking in order of acceptance.
// Depends on kvct_pkg and the RTL of the key/value table.
`default_nettype none

module key_value_cookie_table_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HOLD_OFF_CYCLES = 300;

	typedef struct {
		kvct_pkg::cmd_t             op;
		logic [kvct_pkg::KEY_W-1:0] k;
		logic [kvct_pkg::VAL_W-1:0] v;
	} jar_req_t;

	typedef struct {
		kvct_pkg::status_t          st;
		logic [kvct_pkg::VAL_W-1:0] rd;
		logic [kvct_pkg::CNT_W-1:0] cnt;
	} jar_result_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         in_valid = 1'b0;
	wire logic                    in_ready;
	logic                         cmd = 1'b0;
	logic [kvct_pkg::KEY_W-1:0]   key = '0;
	logic [kvct_pkg::VAL_W-1:0]   value = '0;
	wire logic                    out_valid;
	logic                         out_ready = 1'b0;
	wire logic [1:0]              status;
	wire logic [kvct_pkg::VAL_W-1:0] read_value;
	wire logic [kvct_pkg::CNT_W-1:0] entry_count;
	logic                         cfg_valid = 1'b0;
	wire logic                    cfg_ready;
	logic [kvct_pkg::LIMIT_W-1:0] cfg_data = '0;

	key_value_cookie_table_top uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cmd         (cmd),
		.key         (key),
		.value       (value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.read_value  (read_value),
		.entry_count (entry_count),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	// Stimulus and expectation stores
	jar_req_t                   pending_cmds[$];
	jar_result_t                expected_results[$];
	logic [kvct_pkg::KEY_W-1:0] used_keys[$];

	// Shadow copy of the table
	logic [kvct_pkg::KEY_W-1:0]   jar_keys[kvct_pkg::TABLE_DEPTH];
	logic [kvct_pkg::VAL_W-1:0]   jar_vals[kvct_pkg::TABLE_DEPTH];
	int                           jar_fill = 0;
	logic [kvct_pkg::LIMIT_W-1:0] jar_limit = 5'd31;

	int   fail_count = 0;
	int   tx_idle_pct = 0;
	int   rx_idle_pct = 0;
	logic hold_req = 1'b0;
	logic hold_done = 1'b0;
	int   hold_left = 0;
	logic in_taken = 1'b0;
	logic cfg_taken = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Work out the result of one command and update the shadow table.
	function automatic jar_result_t apply_jar_cmd(jar_req_t r);
		jar_result_t res;
		int          hit;
		int          eff_limit;
		res.st = kvct_pkg::ST_OK;
		res.rd = '0;
		hit = -1;
		eff_limit = (int'(jar_limit) > kvct_pkg::TABLE_DEPTH)
			? kvct_pkg::TABLE_DEPTH : int'(jar_limit);
		if (r.k == '0) begin
			res.st = kvct_pkg::ST_ZERO_KEY;
		end else begin
			for (int i = 0; i < jar_fill; i++) begin
				if (hit < 0 && jar_keys[i] == r.k)
					hit = i;
			end
			if (r.op == kvct_pkg::CMD_SET) begin
				if (hit >= 0) begin
					jar_vals[hit] = r.v;
				end else if (jar_fill < eff_limit) begin
					jar_keys[jar_fill] = r.k;
					jar_vals[jar_fill] = r.v;
					jar_fill++;
				end else begin
					res.st = kvct_pkg::ST_FULL;
				end
			end else begin
				if (hit >= 0)
					res.rd = jar_vals[hit];
				else
					res.st = kvct_pkg::ST_NOT_FOUND;
			end
		end
		res.cnt = jar_fill[kvct_pkg::CNT_W-1:0];
		return res;
	endfunction

	task automatic check_field(string fname, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %0h actual %0h", $realtime, fname, exp_v, act_v);
			fail_count++;
		end
	endtask

	// Driver: present the next queued command once the previous one is taken.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
				in_valid <= 1'b1;
				cmd <= pending_cmds[0].op;
				key <= pending_cmds[0].k;
				value <= pending_cmds[0].v;
				pending_cmds.delete(0);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver back-pressure, with one long hold-off on request.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_req && !hold_done) begin
			out_ready <= 1'b0;
			hold_left <= HOLD_OFF_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	// Monitor: check results, then predict for the newly accepted command.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_taken <= 1'b0;
			cfg_taken <= 1'b0;
		end else begin
			in_taken <= in_valid && in_ready;
			cfg_taken <= cfg_valid && cfg_ready;
			if (cfg_valid && cfg_ready)
				jar_limit = cfg_data;
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result, expected none actual status %0d value %0h count %0d",
						$realtime, status, read_value, entry_count);
					fail_count++;
				end else begin
					check_field("status", 32'(expected_results[0].st), 32'(status));
					check_field("read_value", expected_results[0].rd, read_value);
					check_field("entry_count", 32'(expected_results[0].cnt), 32'(entry_count));
					expected_results.delete(0);
				end
			end
			if (in_valid && in_ready) begin
				jar_req_t r;
				r.op = kvct_pkg::cmd_t'(cmd);
				r.k = key;
				r.v = value;
				expected_results.push_back(apply_jar_cmd(r));
			end
		end
	end

	task automatic queue_cmd(kvct_pkg::cmd_t op, logic [kvct_pkg::KEY_W-1:0] k,
		logic [kvct_pkg::VAL_W-1:0] v);
		jar_req_t r;
		r.op = op;
		r.k = k;
		r.v = v;
		pending_cmds.push_back(r);
		if (op == kvct_pkg::CMD_SET && k != '0)
			used_keys.push_back(k);
	endtask

	// Mostly keys used by earlier sets, some near misses, some fresh keys and zero keys.
	task automatic queue_random(int n);
		kvct_pkg::cmd_t             op;
		logic [kvct_pkg::KEY_W-1:0] k;
		int                         dice;
		for (int i = 0; i < n; i++) begin
			dice = $urandom_range(0, 99);
			op = kvct_pkg::cmd_t'($urandom_range(0, 1));
			if (dice < 5)
				k = '0;
			else if (dice < 60 && used_keys.size() != 0)
				k = used_keys[$urandom_range(0, used_keys.size() - 1)];
			else if (dice < 70 && used_keys.size() != 0)
				k = used_keys[$urandom_range(0, used_keys.size() - 1)] ^
					(32'd1 << $urandom_range(0, 31));
			else
				k = $urandom;
			queue_cmd(op, k, $urandom);
		end
	endtask

	// Hold until every queued command has been taken and answered.
	task automatic drain();
		while (pending_cmds.size() != 0 || in_valid || expected_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_limit(logic [kvct_pkg::LIMIT_W-1:0] lim);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= lim;
		do
			@(negedge clk);
		while (!cfg_taken);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		tx_idle_pct = 13;
		rx_idle_pct = 47;
		write_limit(5'd3);
		queue_cmd(kvct_pkg::CMD_GET, 32'h0000_0001, 32'h0);
		queue_cmd(kvct_pkg::CMD_SET, 32'h0, 32'hFFFF_FFFF);
		queue_cmd(kvct_pkg::CMD_GET, 32'h0, 32'hFFFF_FFFF);
		queue_cmd(kvct_pkg::CMD_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_cmd(kvct_pkg::CMD_SET, 32'h0000_0001, 32'h0);
		queue_cmd(kvct_pkg::CMD_GET, 32'hFFFF_FFFF, 32'h0);
		queue_cmd(kvct_pkg::CMD_GET, 32'h0000_0001, 32'hFFFF_FFFF);
		queue_cmd(kvct_pkg::CMD_SET, 32'h0000_0001, 32'hA5A5_A5A5);
		queue_cmd(kvct_pkg::CMD_SET, 32'h8000_0000, 32'h1234_5678);
		// table full: a new key is refused, an update still lands
		queue_cmd(kvct_pkg::CMD_SET, 32'h0000_0002, 32'h0000_0005);
		queue_cmd(kvct_pkg::CMD_SET, 32'hFFFF_FFFF, 32'h0);
		queue_cmd(kvct_pkg::CMD_GET, 32'h0000_0002, 32'h0);
		queue_cmd(kvct_pkg::CMD_GET, 32'hFFFF_FFFE, 32'h0);
		queue_cmd(kvct_pkg::CMD_GET, 32'h8000_0000, 32'h0);
		queue_cmd(kvct_pkg::CMD_GET, 32'hFFFF_FFFF, 32'h0);
		queue_cmd(kvct_pkg::CMD_GET, 32'h0000_0001, 32'h0);
		drain();

		// a limit of zero permits updates only
		write_limit(5'd0);
		queue_random(20);
		drain();

		write_limit(5'd20);
		hold_req = 1'b1;
		queue_random(120);
		drain();

		tx_idle_pct = 47;
		rx_idle_pct = 13;
		write_limit(5'd31);
		queue_random(130);
		drain();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		write_limit(5'd1);
		queue_random(40);
		drain();
		write_limit(5'd31);
		queue_random(90);
		drain();

		repeat (40) @(negedge clk);
		if (fail_count == 0)
			$display("key_value_cookie_table_top test passed");
		else
			$display("key_value_cookie_table_top test failed");
		$finish;
	end

	initial begin
		#5ms;
		$display("key_value_cookie_table_top test failed");
		$finish;
	end

endmodule

`default_nettype wire

FILE: key_value_cookie_table_top.f
+incdir+hw/rtl
hw/rtl/kvct_pkg.sv
hw/rtl/kvct_cell.sv
hw/rtl/key_value_cookie_table_top.sv
tb/key_value_cookie_table_top_tb.sv
